@@ sv/qbs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qbs_pkg: shared types and constants of the quadratic Bezier sampler
// Coordinate format, sample count limits, controller states and the
// command and status words between the controller and the datapath.
// ----------------------------------------------------------------------------
package qbs_pkg;

  // Coordinate word, Q15.8 two's complement
  localparam int CoordWidth  = 24;
  // Sample count field and its upper limit
  localparam int CountWidth  = 7;
  localparam int MaxSamples  = 64;
  // Curve parameter t in Q0.16
  localparam int TFracWidth  = 16;
  // One quotient bit per step over the dividend 2^TFracWidth
  localparam int DivSteps    = TFracWidth + 1;
  localparam int DivCntWidth = $clog2(DivSteps);
  // Control points per item: three points of three coordinates
  localparam int NumPoints   = 9;
  localparam int NumAxes     = 3;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic [CountWidth-1:0]        count_t;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StRun,
    StDrain
  } qbs_state_e;

  // Controller to datapath
  typedef struct packed {
    logic   load;      // capture control points and count, clear divider
    logic   div_step;  // one restoring division step
    logic   div_msb;   // dividend bit for this step
    logic   issue;     // start one sample at the current t, then advance t
    logic   last;      // the issued sample ends the run
    count_t count;     // clamped sample count, valid with load
  } qbs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;        // final sample of the run is on the outputs
  } qbs_sts_t;

endpackage
`default_nettype wire

@@ sv/qbs_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qbs_ctrl: sequencer of the quadratic Bezier sampler
// Accepts a command word, runs the step division, issues one sample per
// cycle and waits for the last sample to leave the datapath.
// ----------------------------------------------------------------------------
module qbs_ctrl
  import qbs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire count_t   sample_count_i,
  input  wire qbs_sts_t sts_i,
  output qbs_cmd_t      cmd_o,
  output logic          busy_o
);

  qbs_state_e             state_q, state_d;
  logic [DivCntWidth-1:0] div_cnt_q, div_cnt_d;
  count_t                 idx_q, idx_d;
  count_t                 count_q, count_d;
  count_t                 count_clamped;
  logic                   is_last;

  // Clamp the requested count to the supported maximum
  assign count_clamped = (sample_count_i > CountWidth'(MaxSamples)) ?
                         CountWidth'(MaxSamples) : sample_count_i;

  assign is_last = (idx_q == count_q - CountWidth'(1));

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      div_cnt_q <= '0;
      idx_q     <= '0;
      count_q   <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
      idx_q     <= idx_d;
      count_q   <= count_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    div_cnt_d     = div_cnt_q;
    idx_d         = idx_q;
    count_d       = count_q;
    cmd_o         = '0;
    cmd_o.count   = count_clamped;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          count_d    = count_clamped;
          div_cnt_d  = '0;
          if (count_clamped != '0) begin
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_msb  = (div_cnt_q == '0);
        div_cnt_d      = div_cnt_q + DivCntWidth'(1);
        if (div_cnt_q == DivCntWidth'(DivSteps - 1)) begin
          idx_d   = '0;
          state_d = StRun;
        end
      end
      StRun: begin
        cmd_o.issue = 1'b1;
        cmd_o.last  = is_last;
        idx_d       = idx_q + CountWidth'(1);
        if (is_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (sts_i.done) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign busy_o = (state_q != StIdle);

endmodule
`default_nettype wire

@@ sv/qbs_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qbs_dp: datapath of the quadratic Bezier sampler
// Control point store, restoring divider for the t step, t accumulator and a
// three-stage pipeline: Bernstein weights, weighted products, round and clamp.
// ----------------------------------------------------------------------------
module qbs_dp
  import qbs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire qbs_cmd_t cmd_i,
  input  wire coord_t   ctrl_pts_i [NumPoints],
  output qbs_sts_t      sts_o,
  output coord_t        curve_o [NumAxes],
  output logic          result_valid_o,
  output logic          last_sample_o
);

  localparam int WeightWidth = 2 * TFracWidth + 1;
  localparam int SumWidth    = CoordWidth + WeightWidth + 1;
  localparam int QuotWidth   = SumWidth - 2 * TFracWidth;
  localparam int GuardBits   = QuotWidth - CoordWidth + 1;
  localparam int QWidth      = TFracWidth + 1;

  localparam logic signed [SumWidth-1:0] RoundBias =
    {{(SumWidth - 2 * TFracWidth){1'b0}}, 1'b1, {(2 * TFracWidth - 1){1'b0}}};

  // Round to nearest with ties upward, drop 2*TFracWidth fraction bits, clamp
  function automatic coord_t round_sat(input logic signed [SumWidth-1:0] s);
    logic signed [SumWidth-1:0]  biased;
    logic signed [QuotWidth-1:0] quo;
    coord_t                      res;
    biased = s + RoundBias;
    quo    = biased[SumWidth-1:2*TFracWidth];
    if (quo[QuotWidth-1:CoordWidth-1] == {GuardBits{quo[QuotWidth-1]}}) begin
      res = quo[CoordWidth-1:0];
    end else if (quo[QuotWidth-1]) begin
      res = {1'b1, {(CoordWidth-1){1'b0}}};
    end else begin
      res = {1'b0, {(CoordWidth-1){1'b1}}};
    end
    return res;
  endfunction

  coord_t                     pts_q [NumPoints];
  count_t                     n_q;

  // Divider: 2^TFracWidth / n, one quotient bit per step
  count_t                     div_rem_q;
  logic [QWidth-1:0]          div_quo_q;
  logic [CountWidth:0]        div_trial;

  // t accumulator, Q1.16, with fractional remainder
  logic [QWidth-1:0]          t_q;
  count_t                     t_rem_q;
  logic [CountWidth:0]        t_rem_sum;

  // Weight stage
  logic [TFracWidth-1:0]      t_cur;
  logic [QWidth-1:0]          a_cur;
  logic [2*QWidth-1:0]        aa_prod;
  logic [2*QWidth-1:0]        ta_prod;
  logic [2*TFracWidth-1:0]    tt_prod;
  logic [WeightWidth-1:0]     w_q [NumAxes];
  logic                       v1_q, l1_q;

  // Product stage
  logic signed [SumWidth-1:0] prod_q [NumPoints];
  logic                       v2_q, l2_q;

  // Output stage
  coord_t                     curve_q [NumAxes];
  logic                       v3_q, l3_q;

  assign div_trial = {div_rem_q, cmd_i.div_msb};
  assign t_rem_sum = {1'b0, t_rem_q} + {1'b0, div_rem_q};

  // Capture the word, run the divider, advance t on each issued sample
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pts_q     <= ctrl_pts_i;
      n_q       <= cmd_i.count;
      div_rem_q <= '0;
      div_quo_q <= '0;
      t_q       <= '0;
      t_rem_q   <= '0;
    end else if (cmd_i.div_step) begin
      if (div_trial >= {1'b0, n_q}) begin
        div_rem_q <= CountWidth'(div_trial - {1'b0, n_q});
        div_quo_q <= {div_quo_q[QWidth-2:0], 1'b1};
      end else begin
        div_rem_q <= div_trial[CountWidth-1:0];
        div_quo_q <= {div_quo_q[QWidth-2:0], 1'b0};
      end
    end else if (cmd_i.issue) begin
      if (t_rem_sum >= {1'b0, n_q}) begin
        t_rem_q <= CountWidth'(t_rem_sum - {1'b0, n_q});
        t_q     <= t_q + div_quo_q + QWidth'(1);
      end else begin
        t_rem_q <= t_rem_sum[CountWidth-1:0];
        t_q     <= t_q + div_quo_q;
      end
    end
  end

  // Bernstein weights (1-t)^2, 2t(1-t), t^2 scaled by 2^32
  assign t_cur   = t_q[TFracWidth-1:0];
  assign a_cur   = {1'b1, {TFracWidth{1'b0}}} - {1'b0, t_cur};
  assign aa_prod = a_cur * a_cur;
  assign ta_prod = {1'b0, t_cur} * a_cur;
  assign tt_prod = t_cur * t_cur;

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      w_q[0] <= aa_prod[WeightWidth-1:0];
      w_q[1] <= {ta_prod[WeightWidth-2:0], 1'b0};
      w_q[2] <= {1'b0, tt_prod};
    end
  end

  // Weight each control point coordinate
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumPoints; k++) begin
      prod_q[k] <= $signed({1'b0, w_q[k / NumAxes]}) * pts_q[k];
    end
  end

  // Sum per axis, round and clamp
  always_ff @(posedge clk_i) begin
    for (int ax = 0; ax < NumAxes; ax++) begin
      curve_q[ax] <= round_sat(prod_q[ax] + prod_q[ax + NumAxes] +
                               prod_q[ax + 2 * NumAxes]);
    end
  end

  // Advance the valid and last flags with the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      l1_q <= 1'b0;
      v2_q <= 1'b0;
      l2_q <= 1'b0;
      v3_q <= 1'b0;
      l3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      l1_q <= cmd_i.issue & cmd_i.last;
      v2_q <= v1_q;
      l2_q <= l1_q;
      v3_q <= v2_q;
      l3_q <= l2_q;
    end
  end

  assign curve_o        = curve_q;
  assign result_valid_o = v3_q;
  assign last_sample_o  = v3_q & l3_q;
  assign sts_o.done     = v3_q & l3_q;

endmodule
`default_nettype wire

@@ sv/quadratic_bezier_sampler.sv @@
`default_nettype none
// Sequence: once the word is accepted, the bit-serial divider finds the t step,
// then the samples are issued and each passes the 3 pipeline stages.
// Throughput: one sample per cycle once the divider is done; a count of zero
// never raises busy.
// Reset: asynchronous, active low; clears the controller and all result strobes.
// ----------------------------------------------------------------------------
// quadratic_bezier_sampler: quadratic Bezier curve sampler
// Emits N points of the curve through three 3-D control points at
// t = i/N, rounded and clamped to Q15.8, one strobed word per sample.
// ----------------------------------------------------------------------------
module quadratic_bezier_sampler
  import qbs_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   start,
  output logic        busy,
  input  wire coord_t start_x_i,
  input  wire coord_t start_y_i,
  input  wire coord_t start_z_i,
  input  wire coord_t mid_x_i,
  input  wire coord_t mid_y_i,
  input  wire coord_t mid_z_i,
  input  wire coord_t end_x_i,
  input  wire coord_t end_y_i,
  input  wire coord_t end_z_i,
  input  wire count_t sample_count_i,
  output logic        result_valid_o,
  output coord_t      curve_x_o,
  output coord_t      curve_y_o,
  output coord_t      curve_z_o,
  output logic        last_sample_o
);

  qbs_cmd_t cmd;
  qbs_sts_t sts;
  coord_t   ctrl_pts [NumPoints];
  coord_t   curve [NumAxes];

  // Gather the control points in point-major order
  assign ctrl_pts[0] = start_x_i;
  assign ctrl_pts[1] = start_y_i;
  assign ctrl_pts[2] = start_z_i;
  assign ctrl_pts[3] = mid_x_i;
  assign ctrl_pts[4] = mid_y_i;
  assign ctrl_pts[5] = mid_z_i;
  assign ctrl_pts[6] = end_x_i;
  assign ctrl_pts[7] = end_y_i;
  assign ctrl_pts[8] = end_z_i;

  qbs_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .sample_count_i (sample_count_i),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy_o         (busy)
  );

  qbs_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .ctrl_pts_i     (ctrl_pts),
    .sts_o          (sts),
    .curve_o        (curve),
    .result_valid_o (result_valid_o),
    .last_sample_o  (last_sample_o)
  );

  assign curve_x_o = curve[0];
  assign curve_y_o = curve[1];
  assign curve_z_o = curve[2];

endmodule
`default_nettype wire

@@ tb/quadratic_bezier_sampler_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_bezier_sampler_tb: self-checking bench for the Bezier sampler
// Feeds control point sets with sample counts through the start/busy
// handshake. It predicts every curve point from its own exact fixed-point
// evaluation and checks each strobed output word in order. The run covers
// directed extremes, rounding ties, zero and over-range counts, then random
// traffic with varied sender gaps.
// ----------------------------------------------------------------------------
module quadratic_bezier_sampler_tb
  import qbs_pkg::*;
();

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 30;

  localparam coord_t CoordMax = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordWidth-1){1'b0}}};

  typedef coord_t axis_set_t [NumAxes];

  typedef struct {
    axis_set_t start_pt;
    axis_set_t mid_pt;
    axis_set_t end_pt;
    count_t    count;
  } bezier_item_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } curve_point_t;

  // Predicts the curve points of each accepted word and checks the outputs
  class curve_board;
    curve_point_t pending_points[$];
    int           mismatches;
    int           points_checked;

    // Exact weighted sum in Q15.40, round half up to Q15.8, then clamp
    function coord_t blend(coord_t p0, coord_t p1, coord_t p2, longint t);
      longint a, mix, q, hi, lo;
      a   = 65536 - t;
      mix = a * a * longint'(p0) + 2 * t * a * longint'(p1) + t * t * longint'(p2);
      q   = (mix + (longint'(1) <<< 31)) >>> 32;
      hi  = (longint'(1) <<< (CoordWidth - 1)) - 1;
      lo  = -hi - 1;
      if (q > hi) q = hi;
      if (q < lo) q = lo;
      return coord_t'(q);
    endfunction

    // Queue one curve point per sample; counts above the limit are clamped
    function void note_item(bezier_item_t it);
      int           n;
      longint       t;
      curve_point_t pt;
      n = (it.count > MaxSamples) ? MaxSamples : int'(it.count);
      for (int i = 0; i < n; i++) begin
        t       = (longint'(i) * 65536) / n;
        pt.x    = blend(it.start_pt[0], it.mid_pt[0], it.end_pt[0], t);
        pt.y    = blend(it.start_pt[1], it.mid_pt[1], it.end_pt[1], t);
        pt.z    = blend(it.start_pt[2], it.mid_pt[2], it.end_pt[2], t);
        pt.last = (i == n - 1);
        pending_points = {pending_points, pt};
      end
    endfunction

    function void compare_field(string name, coord_t want, coord_t got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    // Match one output word against the oldest predicted point
    function void check_point(curve_point_t got);
      curve_point_t want;
      if (pending_points.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected curve word, expected none actual x=%0d y=%0d z=%0d last=%0b",
                 $time, got.x, got.y, got.z, got.last);
        return;
      end
      want = pending_points.pop_front();
      points_checked++;
      compare_field("curve_x", want.x, got.x);
      compare_field("curve_y", want.y, got.y);
      compare_field("curve_z", want.z, got.z);
      compare_field("last_sample", coord_t'(want.last), coord_t'(got.last));
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni;
  logic   start;
  logic   busy;
  coord_t start_x_i, start_y_i, start_z_i;
  coord_t mid_x_i, mid_y_i, mid_z_i;
  coord_t end_x_i, end_y_i, end_z_i;
  count_t sample_count_i;
  logic   result_valid_o;
  coord_t curve_x_o, curve_y_o, curve_z_o;
  logic   last_sample_o;

  curve_board board;
  int         cycle_count = 0;
  int         items_sent  = 0;
  int         zero_items  = 0;
  int         over_items  = 0;

  quadratic_bezier_sampler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .start_z_i      (start_z_i),
    .mid_x_i        (mid_x_i),
    .mid_y_i        (mid_y_i),
    .mid_z_i        (mid_z_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .end_z_i        (end_z_i),
    .sample_count_i (sample_count_i),
    .result_valid_o (result_valid_o),
    .curve_x_o      (curve_x_o),
    .curve_y_o      (curve_y_o),
    .curve_z_o      (curve_z_o),
    .last_sample_o  (last_sample_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Check every strobed output word at the edge that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      board.check_point(curve_point_t'{curve_x_o, curve_y_o, curve_z_o, last_sample_o});
    end
  end

  function automatic coord_t random_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return coord_t'($urandom);
      5, 6, 7:       return coord_t'(int'($urandom_range(0, 4095)) - 2048);
      8:             return CoordMax;
      default:       return CoordMin;
    endcase
  endfunction

  // Mostly short runs, with some zero and over-range counts
  function automatic count_t random_count();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)  return '0;
    if (pick < 70) return count_t'($urandom_range(1, 16));
    if (pick < 88) return count_t'($urandom_range(17, 64));
    return count_t'($urandom_range(65, 127));
  endfunction

  function automatic bezier_item_t random_item(count_t n);
    bezier_item_t it;
    for (int k = 0; k < NumAxes; k++) begin
      it.start_pt[k] = random_coord();
      it.mid_pt[k]   = random_coord();
      it.end_pt[k]   = random_coord();
    end
    it.count = n;
    return it;
  endfunction

  // Same control values on all three axes
  function automatic bezier_item_t uniform_item(coord_t s, coord_t m, coord_t e, count_t n);
    bezier_item_t it;
    for (int k = 0; k < NumAxes; k++) begin
      it.start_pt[k] = s;
      it.mid_pt[k]   = m;
      it.end_pt[k]   = e;
    end
    it.count = n;
    return it;
  endfunction

  function automatic int pick_gap(int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) return $urandom_range(1, 12);
    return 0;
  endfunction

  // Present one word, optionally after a gap, and hold it until accepted
  task automatic send_item(bezier_item_t it, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    start_x_i      <= it.start_pt[0];
    start_y_i      <= it.start_pt[1];
    start_z_i      <= it.start_pt[2];
    mid_x_i        <= it.mid_pt[0];
    mid_y_i        <= it.mid_pt[1];
    mid_z_i        <= it.mid_pt[2];
    end_x_i        <= it.end_pt[0];
    end_y_i        <= it.end_pt[1];
    end_z_i        <= it.end_pt[2];
    sample_count_i <= it.count;
    do @(posedge clk_i); while (busy);
    board.note_item(it);
    items_sent++;
    if (it.count == 0) zero_items++;
    if (it.count > MaxSamples) over_items++;
  endtask

  // Drop start and wait for all predicted points to arrive
  task automatic drain_results();
    start <= 1'b0;
    while (board.pending_points.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_random(int num_items, int idle_pct);
    for (int k = 0; k < num_items; k++) begin
      send_item(random_item(random_count()), pick_gap(idle_pct));
    end
  endtask

  initial begin
    board          = new;
    rst_ni         = 1'b0;
    start          = 1'b0;
    start_x_i      = '0;
    start_y_i      = '0;
    start_z_i      = '0;
    mid_x_i        = '0;
    mid_y_i        = '0;
    mid_z_i        = '0;
    end_x_i        = '0;
    end_y_i        = '0;
    end_z_i        = '0;
    sample_count_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, rounding ties, zero and over-range counts
    send_item(uniform_item('0, '0, '0, 1), 0);
    send_item(uniform_item(CoordMax, CoordMax, CoordMax, 64), 0);
    send_item(uniform_item(CoordMin, CoordMin, CoordMin, 64), 0);
    send_item(uniform_item(CoordMax, CoordMin, CoordMax, 7), 0);
    send_item(uniform_item(CoordMin, CoordMax, CoordMin, 5), 0);
    send_item(uniform_item('0, coord_t'(1), '0, 2), 0);
    send_item(uniform_item('0, coord_t'(-1), '0, 2), 0);
    send_item(uniform_item(coord_t'(-1), '0, coord_t'(1), 3), 0);
    send_item(random_item('0), 0);
    send_item(random_item('0), 0);
    send_item(uniform_item(coord_t'(3), coord_t'(-5), coord_t'(7), 1), 0);
    send_item(random_item(count_t'(65)), 3);
    send_item(random_item(count_t'(127)), 0);
    send_item(random_item(count_t'(63)), 0);
    send_item(uniform_item(CoordMax, '0, CoordMin, 4), 0);
    send_item(random_item('0), 5);
    send_item(random_item(count_t'(2)), 0);
    drain_results();

    // Random traffic: light sender gaps, heavy gaps, then none
    run_random(70, 16);
    drain_results();
    run_random(70, 64);
    drain_results();
    run_random(63, 0);
    drain_results();

    $display("Sent %0d words (%0d with zero count, %0d above the sample limit)",
             items_sent, zero_items, over_items);
    $display("Checked %0d curve points, %0d mismatches", board.points_checked,
             board.mismatches);
    if (board.mismatches == 0 && board.pending_points.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
